@@ sv/pmfb_pkg.sv @@
// Shared types, constants and command codes for the paged frame buffer.
`default_nettype none
package pmfb_pkg;
    localparam int unsigned COLUMNS_DEF = 128;
    localparam int unsigned PAGES_DEF   = 8;

    typedef enum logic [2:0] {
        OP_PIXEL = 3'd0,
        OP_FILL  = 3'd1,
        OP_IMAGE = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] x;
        logic [5:0] y;
        logic [6:0] height;
        logic [7:0] width;
        logic [2:0] row_index;
        logic [6:0] column_index;
        logic [7:0] image_byte;
        logic       overwrite;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } out_word_t;

    // Classified command handed from front to back.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,  // up to two byte writes, one column
        CMD_FILL  = 2'd1,  // rectangle walk
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] col;        // column (up to 254)
        logic [5:0] page0;      // first page (up to 14)
        logic [7:0] keep0;
        logic [7:0] set0;
        logic       en0;
        logic [7:0] keep1;
        logic [7:0] set1;
        logic       en1;
        logic [5:0] fill_y;
        logic [7:0] fill_last; // last pixel row (up to 189)
        logic [7:0] fill_width;
        logic       nop;        // result only, all zero
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD,
        BK_WR,
        BK_CLEAR,
        BK_DONE
    } bk_state_t;
endpackage
`default_nettype wire

@@ sv/pmfb_front.sv @@
// Front end: accepts commands and turns them into byte-level work.
`default_nettype none
module pmfb_front
    import pmfb_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          q_valid,
    input  wire logic     q_ready,
    output cmd_t          q_cmd
);
    cmd_t       cmd_reg;
    logic       vld_reg;
    cmd_t       c;
    logic [2:0] b;
    logic [7:0] low;
    logic [15:0] sh;
    logic [6:0] row8;

    assign s_ready = !vld_reg || q_ready;
    assign q_valid = vld_reg;
    assign q_cmd   = cmd_reg;

    always_comb begin
        b    = s_data.y[2:0];
        low  = 8'((9'd1 << b) - 9'd1);
        sh   = 16'(s_data.image_byte) << b;
        row8 = {s_data.row_index, 3'b000};
        c = '0;
        c.kind       = CMD_WRITE;
        c.col        = 8'(s_data.x) + 8'(s_data.column_index);
        c.page0      = 6'(s_data.y[5:3]) + 6'(s_data.row_index);
        c.keep0      = 8'hFF;
        c.keep1      = 8'hFF;
        c.fill_y     = s_data.y;
        c.fill_last  = 8'(s_data.y) + 8'(s_data.height) - 8'd1;
        c.fill_width = s_data.width;
        case (s_data.op)
            OP_PIXEL: begin
                c.col   = 8'(s_data.x);
                c.page0 = 6'(s_data.y[5:3]);
                c.set0  = 8'(9'd1 << b);
                c.en0   = 1'b1;
            end
            OP_FILL: begin
                c.kind = CMD_FILL;
                c.col  = 8'(s_data.x);
                c.nop  = (s_data.height == 7'd0) || (s_data.width == 8'd0);
            end
            OP_IMAGE: begin
                c.set0  = sh[7:0];
                c.set1  = sh[15:8];
                c.keep0 = s_data.overwrite ? low : 8'hFF;
                c.keep1 = s_data.overwrite ? ~low : 8'hFF;
                c.en0   = row8 < s_data.height;
                c.en1   = c.en0 && (b != 3'd0)
                          && ((8'(row8) + 8'd8 - 8'(b)) < 8'(s_data.height));
                c.nop   = !c.en0;
            end
            OP_CLEAR: c.kind = CMD_CLEAR;
            OP_READ: begin
                c.kind  = CMD_READ;
                c.col   = 8'(s_data.x);
                c.page0 = 6'(s_data.row_index);
            end
            default: c.nop = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            cmd_reg <= c;
        end
    end
endmodule
`default_nettype wire

@@ sv/pmfb_back.sv @@
// Back end: frame store with read-modify-write sequencer and result register.
`default_nettype none
module pmfb_back
    import pmfb_pkg::*;
#(
    parameter int unsigned COLUMNS = COLUMNS_DEF,
    parameter int unsigned PAGES   = PAGES_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  q_valid,
    output logic       q_ready,
    input  wire cmd_t  q_cmd,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_word_t  m_data
);
    localparam int unsigned DEPTH = COLUMNS * PAGES;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(COLUMNS);
    localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdat_reg;

    bk_state_t  st_reg, st_next;
    cmd_t       cmd_reg;
    logic       part_reg;            // 0: first byte, 1: second byte
    logic [5:0] page_reg;            // current page for fill
    logic [7:0] cidx_reg;            // column offset for fill
    logic [AW:0] clr_reg;
    logic       boot_reg;            // clear pass after reset, no result
    logic       clip_reg;
    out_word_t  res_reg;
    logic       mvld_reg;

    logic [5:0] cur_page;
    logic [8:0] cur_col;
    logic [7:0] cur_keep, cur_set;
    logic       in_range;
    logic [AW-1:0] addr;
    logic [2:0] lo, hi;
    logic       fill_last_col, fill_last_page, step_done;

    assign m_valid = mvld_reg;
    assign m_data  = res_reg;
    assign q_ready = (st_reg == BK_IDLE);

    always_comb begin
        lo = (page_reg == 6'(cmd_reg.fill_y[5:3])) ? cmd_reg.fill_y[2:0] : 3'd0;
        hi = (page_reg == 6'(cmd_reg.fill_last[7:3])) ? cmd_reg.fill_last[2:0] : 3'd7;
        cur_page = cmd_reg.page0;
        cur_col  = 9'(cmd_reg.col);
        cur_keep = cmd_reg.keep0;
        cur_set  = cmd_reg.set0;
        if (cmd_reg.kind == CMD_FILL) begin
            cur_page = page_reg;
            cur_col  = 9'(cmd_reg.col) + 9'(cidx_reg);
            cur_keep = 8'hFF;
            cur_set  = (8'hFF >> (3'd7 - hi)) & (8'hFF << lo);
        end else if (part_reg) begin
            cur_page = cmd_reg.page0 + 6'd1;
            cur_keep = cmd_reg.keep1;
            cur_set  = cmd_reg.set1;
        end
        in_range = (32'(cur_page) < PAGES) && (32'(cur_col) < COLUMNS);
        addr = AW'(32'(cur_page[PW-1:0]) * COLUMNS + 32'(cur_col[CW-1:0]));
        fill_last_col  = (cidx_reg == cmd_reg.fill_width - 8'd1);
        fill_last_page = (page_reg == 6'(cmd_reg.fill_last[7:3]));
        if (cmd_reg.kind == CMD_FILL) begin
            step_done = fill_last_col && fill_last_page;
        end else begin
            step_done = part_reg || !cmd_reg.en1;
        end
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            BK_IDLE: if (q_valid) begin
                unique case (q_cmd.kind)
                    CMD_CLEAR: st_next = BK_CLEAR;
                    default:   st_next = (q_cmd.nop) ? BK_DONE : BK_RD;
                endcase
                if (q_cmd.kind == CMD_WRITE && !q_cmd.en0) st_next = BK_DONE;
            end
            BK_RD: st_next = (cmd_reg.kind == CMD_READ) ? BK_DONE
                             : (in_range ? BK_WR : (step_done ? BK_DONE : BK_RD));
            BK_WR: st_next = step_done ? BK_DONE : BK_RD;
            BK_CLEAR: st_next = (clr_reg == (AW+1)'(DEPTH - 1))
                                ? (boot_reg ? BK_IDLE : BK_DONE) : BK_CLEAR;
            BK_DONE: st_next = (!mvld_reg || m_ready) ? BK_IDLE : BK_DONE;
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= BK_CLEAR;
            clr_reg  <= '0;
            boot_reg <= 1'b1;
            mvld_reg <= 1'b0;
            clip_reg <= 1'b0;
            part_reg <= 1'b0;
            page_reg <= '0;
            cidx_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (st_reg == BK_DONE && (!mvld_reg || m_ready)) begin
                mvld_reg <= 1'b1;
            end else if (m_ready) begin
                mvld_reg <= 1'b0;
            end
            unique case (st_reg)
                BK_IDLE: if (q_valid) begin
                    cmd_reg  <= q_cmd;
                    clip_reg <= 1'b0;
                    part_reg <= 1'b0;
                    page_reg <= 6'(q_cmd.fill_y[5:3]);
                    cidx_reg <= '0;
                    clr_reg  <= '0;
                end
                BK_RD: begin
                    if (!in_range) clip_reg <= 1'b1;
                    if (!in_range && cmd_reg.kind != CMD_READ && !step_done) begin
                        if (cmd_reg.kind == CMD_FILL) begin
                            if (fill_last_col) begin
                                cidx_reg <= '0;
                                page_reg <= page_reg + 6'd1;
                            end else begin
                                cidx_reg <= cidx_reg + 8'd1;
                            end
                        end else begin
                            part_reg <= 1'b1;
                        end
                    end
                end
                BK_WR: begin
                    if (cmd_reg.kind == CMD_FILL) begin
                        if (fill_last_col) begin
                            cidx_reg <= '0;
                            page_reg <= page_reg + 6'd1;
                        end else begin
                            cidx_reg <= cidx_reg + 8'd1;
                        end
                    end else begin
                        part_reg <= 1'b1;
                    end
                end
                BK_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(DEPTH - 1)) boot_reg <= 1'b0;
                end
                BK_DONE: if (!mvld_reg || m_ready) begin
                    res_reg.read_data <= (cmd_reg.kind == CMD_READ && in_range)
                                         ? rdat_reg : 8'd0;
                    res_reg.clipped   <= (cmd_reg.kind == CMD_READ) ? !in_range
                                         : clip_reg;
                end
                default: ;
            endcase
        end
    end

    // Store: one read and one write port, read data registered.
    always_ff @(posedge aclk) begin
        if (st_reg == BK_RD && in_range) begin
            rdat_reg <= mem[addr];
        end
        if (st_reg == BK_WR) begin
            mem[addr] <= (rdat_reg & cur_keep) | cur_set;
        end else if (st_reg == BK_CLEAR) begin
            mem[clr_reg[AW-1:0]] <= 8'd0;
        end
    end
endmodule
`default_nettype wire

@@ sv/paged_mono_framebuffer_draw.sv @@
// Top level: command front end, one-deep queue register, store sequencer.
// Clear walks the whole store, one byte a cycle.
// Throughput limited by the sequencer: each byte is read, then written back.
// After reset the store is cleared before work.
// Reset is synchronous, active low; the result register holds one word.
`default_nettype none
module paged_mono_framebuffer_draw
    import pmfb_pkg::*;
#(
    parameter int unsigned COLUMNS = COLUMNS_DEF,
    parameter int unsigned PAGES   = PAGES_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_word_t     m_data
);
    logic q_valid, q_ready;
    cmd_t q_cmd;

    pmfb_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_cmd
    );

    pmfb_back #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

@@ sv/pmfb_checker.sv @@
// Port-level checker for the frame buffer, bound to the top level.
`default_nettype none
module pmfb_checker
    import pmfb_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_word_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.clipped |-> m_data.read_data == 8'd0)
        else $error("clipped result with data");
    a_no_out_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");
endmodule

bind paged_mono_framebuffer_draw pmfb_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
);
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the paged monochrome frame buffer draw block.
`default_nettype none
module testbench;
    import pmfb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOL = 128;
    localparam int NPAGE = 8;
    localparam int WATCHDOG = 40000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;

    always #1 aclk = ~aclk;

    paged_mono_framebuffer_draw dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    logic [7:0] pixels [NPAGE*NCOL];
    out_word_t expected_words[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int sink_gap = 0;
    bit sink_idle_on = 1'b1;
    bit src_idle_on = 1'b1;
    bit hold_sink = 1'b0;

    // Writes (old & keep) | set; returns 1 when the byte lands outside.
    function automatic bit put_byte(int page, int col, logic [7:0] keep, logic [7:0] set);
        if (page >= NPAGE || col >= NCOL) return 1'b1;
        pixels[page*NCOL+col] = (pixels[page*NCOL+col] & keep) | set;
        return 1'b0;
    endfunction

    function automatic out_word_t draw_predict(in_word_t w);
        out_word_t r;
        int b, p, c, last, lo, hi;
        logic [7:0] mask, low;
        r = '0;
        case (w.op)
            OP_PIXEL: r.clipped = put_byte(w.y >> 3, w.x, 8'hFF, 8'h01 << w.y[2:0]);
            OP_FILL: if (w.height != 0 && w.width != 0) begin
                last = w.y + w.height - 1;
                for (p = w.y >> 3; p <= (last >> 3); p++) begin
                    lo = (p == (w.y >> 3)) ? w.y % 8 : 0;
                    hi = (p == (last >> 3)) ? last % 8 : 7;
                    mask = (8'hFF >> (7 - hi)) & (8'hFF << lo);
                    for (c = 0; c < w.width; c++)
                        if (put_byte(p, w.x + c, 8'hFF, mask)) r.clipped = 1'b1;
                end
            end
            OP_IMAGE: begin
                b = w.y % 8;
                p = (w.y >> 3) + w.row_index;
                c = w.x + w.column_index;
                if (8 * w.row_index < w.height) begin
                    low = (8'h01 << b) - 8'h01;
                    if (put_byte(p, c, w.overwrite ? low : 8'hFF, w.image_byte << b))
                        r.clipped = 1'b1;
                    if (b != 0 && 8 * w.row_index + 8 - b < w.height)
                        if (put_byte(p + 1, c, w.overwrite ? ~low : 8'hFF,
                                     w.image_byte >> (8 - b)))
                            r.clipped = 1'b1;
                end
            end
            OP_CLEAR: foreach (pixels[i]) pixels[i] = '0;
            OP_READ: r.read_data = pixels[w.row_index*NCOL + w.x];
            default: ;
        endcase
        return r;
    endfunction

    // Valid stays up after a word is taken; the next call replaces the word
    // at the same falling edge, an idle gap or drain() drops it.
    task automatic send_word(in_word_t w);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_data <= w;
        s_valid <= 1'b1;
        expected_words.push_back(draw_predict(w));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic in_word_t rand_word(logic [2:0] op);
        in_word_t w;
        w = '0;
        w.op = op;
        w.x = 7'($urandom);
        w.y = 6'($urandom);
        w.height = 7'($urandom_range(0, 64));
        w.width = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 128))
                                              : 8'($urandom_range(0, 6));
        w.row_index = 3'($urandom);
        w.column_index = ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                     : 7'($urandom_range(0, 15));
        w.image_byte = 8'($urandom);
        w.overwrite = 1'($urandom);
        return w;
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
    endtask

    // Sink side: random stall bursts, plus a long hold when asked.
    always @(negedge aclk) begin
        if (!aresetn || hold_sink) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_data);
            end else begin
                out_word_t e;
                e = expected_words.pop_front();
                if (e.read_data !== m_data.read_data || e.clipped !== m_data.clipped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp data %h clip %b, got data %h clip %b",
                                 e.read_data, e.clipped, m_data.read_data, m_data.clipped);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        in_word_t w;
        w = '0; w.op = OP_PIXEL; send_word(w);
        w.x = 127; w.y = 63; send_word(w);
        w = '0; w.op = OP_FILL; w.x = 120; w.y = 3; w.height = 64; w.width = 128; send_word(w);
        w.height = 0; send_word(w);
        w.height = 5; w.width = 0; send_word(w);
        w = '0; w.op = OP_READ; w.x = 127; w.row_index = 7; send_word(w);
        w = '0; w.op = OP_CLEAR; send_word(w);
        w = '0; w.op = OP_IMAGE; w.x = 10; w.y = 5; w.height = 64; w.image_byte = 8'hFF;
        send_word(w);
        w.row_index = 1; w.overwrite = 1; w.image_byte = 8'h00; send_word(w);
        w.row_index = 7; w.column_index = 127; w.x = 127; w.y = 63; send_word(w);
        w.height = 0; send_word(w);
        w = '0; w.op = OP_READ; w.x = 10; w.row_index = 1; send_word(w);
        w.row_index = 0; send_word(w);
        w.row_index = 2; send_word(w);
        w = '0; w.op = 3'd5; w.x = 1; send_word(w);
        w.op = 3'd7; w = ~w; w.op = 3'd7; send_word(w);
        w = '1; w.op = OP_IMAGE; send_word(w);
        drain();
    endtask

    task automatic test_random(int n);
        int k;
        logic [2:0] op;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: op = OP_PIXEL;
                4, 5, 6: op = OP_FILL;
                7, 8, 9, 10, 11, 12, 13: op = OP_IMAGE;
                14: op = ($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_READ;
                15, 16, 17: op = OP_READ;
                default: op = 3'($urandom_range(0, 7));
            endcase
            send_word(rand_word(op));
        end
        drain();
    endtask

    task automatic test_backpressure();
        int k;
        hold_sink = 1'b1;
        fork
            begin
                repeat (300) @(negedge aclk);
                hold_sink = 1'b0;
            end
            for (k = 0; k < 20; k++) send_word(rand_word(OP_PIXEL));
        join
        drain();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        foreach (pixels[i]) pixels[i] = '0;
        test_directed();
        test_random(700);
        test_backpressure();
        test_random(250);
        sink_idle_on = 1'b0;
        src_idle_on = 1'b0;
        test_random(120);
        repeat (50) @(negedge aclk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
sv/pmfb_pkg.sv
sv/pmfb_front.sv
sv/pmfb_back.sv
sv/paged_mono_framebuffer_draw.sv
sv/pmfb_checker.sv
dv/testbench.sv
